/* hw/rtl/scancode_decoder_with_event_fifo_top_macros.svh */
// Assertion macros shared by the scancode decoder RTL.
`ifndef SCANCODE_DECODER_WITH_EVENT_FIFO_TOP_MACROS_SVH
`define SCANCODE_DECODER_WITH_EVENT_FIFO_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/scd_pkg.sv */
// Types, codes and layout tables for the scancode decoder.
package scd_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int ROM_SIZE    = 59;
    localparam logic [3:0] PEND_MAX = 4'd15;

    localparam logic [1:0] FUNC_SCAN = 2'd0;
    localparam logic [1:0] FUNC_READ = 2'd1;
    localparam logic [1:0] FUNC_POLL = 2'd2;

    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_ALT    = 7'h38;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;
    localparam logic [6:0] CAPS_LO    = 7'h10;
    localparam logic [6:0] CAPS_HI    = 7'h32;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] scan_code;
    } req_t;

    typedef struct packed {
        logic       has_event;
        logic       released;
        logic [6:0] key_code;
        logic [3:0] modifiers;
        logic [6:0] key_char;
        logic [3:0] pending;
        logic       last;
    } rsp_t;

    // One queued key event as stored in the ring memory.
    typedef struct packed {
        logic       released;
        logic [6:0] key_code;
        logic [3:0] modifiers;
        logic [6:0] key_char;
    } kev_t;

    typedef struct packed {
        logic push;
        kev_t kev;
    } key_push_t;

    localparam logic [6:0] ROM_PLAIN [0:ROM_SIZE-1] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08,
        7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F,
        7'h70, 7'h5B, 7'h5D, 7'h0A,
        7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C,
        7'h3B, 7'h27, 7'h60,
        7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
        7'h2E, 7'h2F, 7'h00,
        7'h2A, 7'h00, 7'h20, 7'h00
    };

    localparam logic [6:0] ROM_SHIFT [0:ROM_SIZE-1] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08,
        7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F,
        7'h50, 7'h7B, 7'h7D, 7'h0A,
        7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C,
        7'h3A, 7'h22, 7'h7E,
        7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
        7'h3E, 7'h3F, 7'h00,
        7'h2A, 7'h00, 7'h20, 7'h00
    };

    function automatic logic [6:0] key_char_lookup(input logic [6:0] code,
                                                   input logic use_shift);
        logic [6:0] ch;
        ch = 7'h00;
        if (code < 7'(ROM_SIZE)) begin
            ch = use_shift ? ROM_SHIFT[code[5:0]] : ROM_PLAIN[code[5:0]];
        end
        return ch;
    endfunction

endpackage

/* hw/rtl/scd_ram.sv */
// Generic simple dual-port RAM with registered read data.
module scd_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/scd_keymap.sv */
// Modifier tracking and scancode-to-event translation.
module scd_keymap
    import scd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  logic [7:0] scan_code,
    output key_push_t kp
);

    logic shift_reg, shift_next;
    logic ctrl_reg, ctrl_next;
    logic alt_reg, alt_next;
    logic caps_reg, caps_next;

    logic       rel;
    logic [6:0] code;
    logic       is_mod;
    logic       use_shift;

    assign rel  = scan_code[7];
    assign code = scan_code[6:0];

    always_comb
    begin
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        alt_next   = alt_reg;
        caps_next  = caps_reg;
        is_mod     = 1'b1;
        case (code)
            KEY_LSHIFT, KEY_RSHIFT: shift_next = !rel;
            KEY_CTRL:               ctrl_next  = !rel;
            KEY_ALT:                alt_next   = !rel;
            KEY_CAPS:               caps_next  = rel ? caps_reg : !caps_reg;
            default:                is_mod     = 1'b0;
        endcase
    end

    // Caps lock flips the shift choice on the letter rows only.
    assign use_shift = shift_reg ^ (caps_reg && code >= CAPS_LO && code <= CAPS_HI);

    always_comb
    begin
        kp.push          = take && !is_mod;
        kp.kev.released  = rel;
        kp.kev.key_code  = code;
        kp.kev.modifiers = {caps_reg, alt_reg, ctrl_reg, shift_reg};
        kp.kev.key_char  = key_char_lookup(code, use_shift);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            ctrl_reg  <= 1'b0;
            alt_reg   <= 1'b0;
            caps_reg  <= 1'b0;
        end
        else if (take)
        begin
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
            alt_reg   <= alt_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

/* hw/rtl/scancode_decoder_with_event_fifo_top.sv */
// Top level: set-1 scancode decoder feeding a key event ring buffer.
//
// A scancode byte, unless it is a modifier key, is written into the event memory
// in the same cycle that it is taken; an event arriving with the ring full
// (QUEUE_DEPTH-1 entries) is dropped. A poll returns one transaction with the
// saturated pending count. A read fetches each event through the event memory's
// registered read, from issuing an address to forwarding its data, and holds
// while the result slot is busy; it returns up to min(READ_BURST, 16) events,
// the last one marked, or one empty transaction. The request side is stalled
// while a poll or read is in progress; results wait in an output register.
`include "scancode_decoder_with_event_fifo_top_macros.svh"

module scancode_decoder_with_event_fifo_top
    import scd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int READ_BURST  = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int BURST_LIMIT = (READ_BURST < MAX_RESULTS) ? READ_BURST : MAX_RESULTS;
    localparam int BURST_W     = $clog2(BURST_LIMIT) + 1;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_POLL    = 2'd1;
    localparam logic [1:0] ST_RD_ADDR = 2'd2;
    localparam logic [1:0] ST_RD_DATA = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   count_reg, count_next;
    logic [BURST_W-1:0] burst_reg, burst_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic      accept;
    logic      take_scan;
    logic      full;
    logic      out_free;
    logic      last_evt;
    logic      ram_we;
    logic      ram_re;
    kev_t      ram_rdata;
    key_push_t kp;
    logic [3:0] pending_sat;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign take_scan = accept && (req.func == FUNC_SCAN);
    assign full      = (count_reg == PTR_W'(QUEUE_DEPTH - 1));
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign ram_we    = kp.push && !full;

    assign pending_sat = (32'(count_reg) > 32'(PEND_MAX)) ? PEND_MAX : 4'(count_reg);
    assign last_evt    = (count_reg == PTR_W'(1)) ||
                         (burst_reg == BURST_W'(BURST_LIMIT - 1));

    scd_keymap u_keymap (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take_scan),
        .scan_code (req.scan_code),
        .kp        (kp)
    );

    scd_ram #(
        .WIDTH ($bits(kev_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (kp.kev),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        count_next     = count_reg;
        burst_next     = burst_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_re         = 1'b0;

        if (ram_we)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
            count_next  = count_reg + PTR_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.func == FUNC_POLL)
                begin
                    state_next = ST_POLL;
                end
                else if (accept && req.func == FUNC_READ)
                begin
                    state_next = ST_RD_ADDR;
                    burst_next = '0;
                end
            end
            ST_POLL:
            begin
                if (out_free)
                begin
                    rsp_next         = '0;
                    rsp_next.pending = pending_sat;
                    rsp_next.last    = 1'b1;
                    rsp_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_RD_ADDR:
            begin
                if (count_reg != '0)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_RD_DATA;
                end
                else if (out_free)
                begin
                    rsp_next       = '0;
                    rsp_next.last  = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_RD_DATA:
            begin
                // Hold the fetched entry in the RAM output until the result slot frees.
                if (out_free)
                begin
                    rsp_next.has_event = 1'b1;
                    rsp_next.released  = ram_rdata.released;
                    rsp_next.key_code  = ram_rdata.key_code;
                    rsp_next.modifiers = ram_rdata.modifiers;
                    rsp_next.key_char  = ram_rdata.key_char;
                    rsp_next.pending   = 4'd0;
                    rsp_next.last      = last_evt;
                    rsp_valid_next     = 1'b1;
                    rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + PTR_W'(1);
                    count_next  = count_reg - PTR_W'(1);
                    burst_next  = burst_reg + BURST_W'(1);
                    state_next  = last_evt ? ST_IDLE : ST_RD_ADDR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            burst_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            burst_reg     <= burst_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SCD_ASSERT(a_count_ptrs, (count_reg == '0) == (wr_ptr_reg == rd_ptr_reg), "count disagrees with pointers")
    `SCD_ASSERT(a_no_rw_overlap, !(ram_we && ram_re), "event memory written and read together")
    `SCD_ASSERT(a_rd_nonempty, (state_reg != ST_RD_DATA) || (count_reg != '0), "read data state with empty ring")
    `SCD_ASSERT_NEXT(a_re_to_data, ram_re, state_reg == ST_RD_DATA, "memory read not followed by data state")

endmodule

/* tb/tb_scancode_decoder_with_event_fifo_top.sv */
// Self-checking testbench for the scancode decoder with key event ring buffer.
module tb_scancode_decoder_with_event_fifo_top;
    import scd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH   = 16;
    localparam int BURST_MAX    = 16;
    localparam int RANDOM_ITEMS = 390;
    localparam int CALM_TAIL    = 60;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    scancode_decoder_with_event_fifo_top #(
        .QUEUE_DEPTH(RING_DEPTH),
        .READ_BURST (BURST_MAX)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    // US layout, unshifted and shifted, indexed by key code
    logic [6:0] us_lower [0:ROM_SIZE-1];
    logic [6:0] us_upper [0:ROM_SIZE-1];

    // Decoder state as the testbench sees it
    logic       held_shift;
    logic       held_ctrl;
    logic       held_alt;
    logic       caps_active;
    kev_t       key_ring [0:RING_DEPTH-1];
    logic [3:0] ring_rd;
    logic [3:0] ring_wr;

    req_t scan_req_backlog [$];
    rsp_t key_rsp_expected [$];

    int unsigned cycle_cnt;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned stuck_cycles;
    int unsigned mismatch_cnt;

    function automatic bit idling_ok();
        return scan_req_backlog.size() >= CALM_TAIL && cycle_cnt[8:7] != 2'd0;
    endfunction

    // Update decoder state for one request and queue the results it causes.
    function automatic void predict_key_results(input req_t r);
        logic       rel;
        logic [6:0] code;
        logic       upper;
        kev_t       ev;
        rsp_t       res;
        int         queued;
        int         take;
        rel  = r.scan_code[7];
        code = r.scan_code[6:0];
        case (r.func)
            FUNC_SCAN:
            begin
                if (code == KEY_LSHIFT || code == KEY_RSHIFT)
                begin
                    held_shift = !rel;
                end
                else if (code == KEY_CTRL)
                begin
                    held_ctrl = !rel;
                end
                else if (code == KEY_ALT)
                begin
                    held_alt = !rel;
                end
                else if (code == KEY_CAPS)
                begin
                    if (!rel) caps_active = !caps_active;
                end
                else
                begin
                    ev.released  = rel;
                    ev.key_code  = code;
                    ev.modifiers = {caps_active, held_alt, held_ctrl, held_shift};
                    upper = held_shift;
                    if (caps_active && code >= CAPS_LO && code <= CAPS_HI) upper = !upper;
                    if (code < 7'(ROM_SIZE))
                        ev.key_char = upper ? us_upper[code[5:0]] : us_lower[code[5:0]];
                    else
                        ev.key_char = 7'h00;
                    // keep one slot free, drop when full
                    if (4'(ring_wr + 4'd1) != ring_rd)
                    begin
                        key_ring[ring_wr] = ev;
                        ring_wr = 4'(ring_wr + 4'd1);
                    end
                end
            end
            FUNC_POLL:
            begin
                res = '0;
                res.pending = 4'(ring_wr - ring_rd);
                res.last = 1'b1;
                key_rsp_expected.push_back(res);
            end
            FUNC_READ:
            begin
                queued = int'(4'(ring_wr - ring_rd));
                take = (queued < BURST_MAX) ? queued : BURST_MAX;
                if (take == 0)
                begin
                    res = '0;
                    res.last = 1'b1;
                    key_rsp_expected.push_back(res);
                end
                for (int i = 0; i < take; i++)
                begin
                    ev = key_ring[ring_rd];
                    res = '0;
                    res.has_event = 1'b1;
                    res.released  = ev.released;
                    res.key_code  = ev.key_code;
                    res.modifiers = ev.modifiers;
                    res.key_char  = ev.key_char;
                    res.last      = (i == take - 1);
                    key_rsp_expected.push_back(res);
                    ring_rd = 4'(ring_rd + 4'd1);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void add_req(input logic [1:0] f, input logic [7:0] code);
        req_t r;
        r.func = f;
        r.scan_code = code;
        scan_req_backlog.push_back(r);
    endfunction

    // Mostly the typing range, now and then any key code.
    function automatic logic [7:0] random_key_byte();
        logic [6:0] code;
        if ($urandom_range(0, 4) != 0)
            code = 7'($urandom_range(0, 58));
        else
            code = 7'($urandom_range(0, 127));
        return {($urandom_range(0, 2) == 0), code};
    endfunction

    // Press or release one of the modifier keys.
    function automatic logic [7:0] random_modifier_byte(input bit pressed);
        logic [6:0] code;
        case ($urandom_range(0, 4))
            0: code = KEY_LSHIFT;
            1: code = KEY_RSHIFT;
            2: code = KEY_CTRL;
            3: code = KEY_ALT;
            default: code = KEY_CAPS;
        endcase
        return {!pressed, code};
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            send_gap  <= 0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (send_gap > 0)
            begin
                send_gap  <= send_gap - 1;
                req_valid <= 1'b0;
            end
            else if (scan_req_backlog.size() == 0)
            begin
                req_valid <= 1'b0;
            end
            else if (idling_ok() && $urandom_range(0, 7) == 0)
            begin
                send_gap  <= $urandom_range(0, 14);
                req_valid <= 1'b0;
            end
            else
            begin
                req       <= scan_req_backlog.pop_front();
                req_valid <= 1'b1;
            end
        end
    end

    // Result-side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
        end
        else if (idling_ok() && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 14);
            rsp_stall  <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // Check results first: a request taken at this edge cannot have a result yet.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (key_rsp_expected.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("unexpected transaction %p", rsp);
                end
                else
                begin
                    want = key_rsp_expected.pop_front();
                    if (rsp.has_event !== want.has_event || rsp.released !== want.released ||
                        rsp.key_code !== want.key_code || rsp.modifiers !== want.modifiers ||
                        rsp.key_char !== want.key_char || rsp.pending !== want.pending ||
                        rsp.last !== want.last)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX)
                            $display("mismatch: expected %p actual %p", want, rsp);
                    end
                end
            end
            if (req_valid && !req_stall) predict_key_results(req);
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("tb_scancode_decoder_with_event_fifo_top NOT OK");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        int made;
        int burst;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        rsp_stall    = 1'b0;
        cycle_cnt    = 0;
        send_gap     = 0;
        stall_left   = 0;
        stuck_cycles = 0;
        mismatch_cnt = 0;
        held_shift   = 1'b0;
        held_ctrl    = 1'b0;
        held_alt     = 1'b0;
        caps_active  = 1'b0;
        ring_rd      = '0;
        ring_wr      = '0;
        us_lower = '{
            7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
            7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
            7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
            7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
            7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
            7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
            7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
            7'h00, 7'h20, 7'h00
        };
        us_upper = '{
            7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
            7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
            7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
            7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
            7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
            7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
            7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
            7'h00, 7'h20, 7'h00
        };

        // Directed: empty queue, unused func, field extremes, every modifier, caps range
        add_req(FUNC_READ, 8'h00);
        add_req(FUNC_POLL, 8'hFF);
        add_req(2'd3, 8'hFF);
        add_req(FUNC_SCAN, 8'h00);
        add_req(FUNC_SCAN, 8'hFF);
        add_req(FUNC_SCAN, {1'b0, CAPS_LO});
        add_req(FUNC_SCAN, {1'b0, KEY_CAPS});
        add_req(FUNC_SCAN, {1'b1, KEY_CAPS});
        add_req(FUNC_SCAN, {1'b0, CAPS_LO});
        add_req(FUNC_SCAN, {1'b1, CAPS_HI});
        add_req(FUNC_SCAN, 8'h33);
        add_req(FUNC_SCAN, 8'h0F);
        add_req(FUNC_SCAN, {1'b0, KEY_LSHIFT});
        add_req(FUNC_SCAN, {1'b0, CAPS_LO});
        add_req(FUNC_SCAN, 8'h03);
        add_req(FUNC_SCAN, {1'b1, KEY_LSHIFT});
        add_req(FUNC_SCAN, {1'b0, KEY_RSHIFT});
        add_req(FUNC_SCAN, {1'b0, KEY_CTRL});
        add_req(FUNC_SCAN, {1'b0, KEY_ALT});
        add_req(FUNC_SCAN, 8'h3B);
        add_req(FUNC_POLL, 8'h00);
        add_req(FUNC_READ, 8'hFF);
        add_req(FUNC_SCAN, {1'b1, KEY_RSHIFT});
        add_req(FUNC_SCAN, {1'b1, KEY_CTRL});
        add_req(FUNC_SCAN, {1'b1, KEY_ALT});

        // Random: typing sequences with reads and polls, some noise in between
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    add_req(FUNC_SCAN, random_modifier_byte(1'b1));
                    made++;
                end
                burst = $urandom_range(1, 20);
                for (int i = 0; i < burst; i++) add_req(FUNC_SCAN, random_key_byte());
                made += burst;
                if ($urandom_range(0, 2) == 0)
                begin
                    add_req(FUNC_SCAN, random_modifier_byte(1'b0));
                    made++;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    add_req(FUNC_POLL, 8'($urandom_range(0, 255)));
                    made++;
                end
                if ($urandom_range(0, 9) < 6)
                begin
                    add_req(FUNC_READ, 8'($urandom_range(0, 255)));
                    made++;
                end
            end
            else
            begin
                burst = $urandom_range(1, 4);
                for (int i = 0; i < burst; i++)
                begin
                    add_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                    if (scan_req_backlog[$].func != 2'd3) made++;
                end
            end
        end
        // Drain whatever is still queued.
        add_req(FUNC_READ, 8'h00);
        add_req(FUNC_POLL, 8'h00);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (scan_req_backlog.size() != 0 || req_valid) @(posedge clk);
        while (key_rsp_expected.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && key_rsp_expected.size() == 0)
        begin
            $display("tb_scancode_decoder_with_event_fifo_top OK");
        end
        else
        begin
            $display("tb_scancode_decoder_with_event_fifo_top NOT OK");
        end
        $finish;
    end

endmodule
